// ----- design/lnorm_pkg.sv -----
// Shared widths and constants for the layer normalizer.
`timescale 1ns / 1ps
package lnorm_pkg;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned SUM_W  = 23;
  localparam int unsigned EPS_W  = 16;
  localparam int unsigned DIV_DW = 38;
  localparam int unsigned DIV_VW = 25;
  localparam int unsigned SQRT_W = 50;
  localparam int unsigned ROOT_W = 25;
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned VAR_W  = 32;
  localparam int unsigned NORM_SHIFT = 18;
  localparam logic signed [ELEM_W-1:0] SAT_POS = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0] SAT_NEG = 16'sh8000;
endpackage

// ----- design/lnorm_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lnorm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- design/lnorm_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module lnorm_div #(
  parameter int unsigned DW = 38,
  parameter int unsigned VW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);
  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [VW:0]      rem_q, rem_sh, rem_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [VW-1:0]    div_q;

  always_comb begin
    rem_sh = {rem_q[VW-1:0], quo_q[DW-1]};
    if (rem_sh >= {1'b0, div_q}) begin
      rem_d = rem_sh - {1'b0, div_q};
      quo_d = {quo_q[DW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh;
      quo_d = {quo_q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ----- design/lnorm_sqrt.sv -----
// Floor integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module lnorm_sqrt #(
  parameter int unsigned W = 50
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   value_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);
  localparam int unsigned CNT_W = $clog2(W / 2 + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [W-1:0]     v_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(W / 2);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= {2'b01, {(W-2){1'b0}}};
    end else if (cnt_q != '0) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[W/2-1:0];
endmodule

// ----- design/layer_normalizer.sv -----
// Layer normalizer top level: load, statistics sequencer and result register.
//
// Input beats carry one signed Q8.8 element each; the beat with last_i set
// closes the vector. While loading, one beat is taken per cycle. Up to
// MAX_LEN elements are stored; later ones are dropped and every result of
// that vector then has truncated_o set.
// After the closing beat in_stall_o stays high until the last result beat
// has been taken. The block then runs the mean divide, a variance pass
// that reads, squares and accumulates each element, the variance divide,
// the square root of variance plus epsilon, and for every element one
// divide (skipped when the root is zero). The divides share one bit-serial
// divider; the square root has its own bit-serial unit. Each result is
// computed only after the previous result beat has been taken.
// Results come out in element order, with last_res_o on the final one.
// When out_stall_i is high the result register holds and the sequence waits.
// eps_we_i writes the epsilon, which is used at the square root step.
// Reset clears the element count, sum and flags and sets epsilon to 1;
// the element memory is not cleared.
`timescale 1ns / 1ps
module layer_normalizer #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lnorm_pkg::ELEM_W-1:0] element_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lnorm_pkg::ELEM_W-1:0] normalized_o,
  output logic                                last_res_o,
  output logic                                truncated_o,
  input  logic                                eps_we_i,
  input  logic [lnorm_pkg::EPS_W-1:0]         eps_wdata_i
);
  import lnorm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_MEAN, S_VRD, S_VSQ, S_VACC, S_VDIV, S_ROOT,
    S_ORD, S_OCALC, S_ODIV, S_OUT
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             cnt_q, n_q;
  logic [AW-1:0]             idx_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      ovf_q;
  logic [EPS_W-1:0]          eps_q;
  logic signed [ELEM_W-1:0]  mean_q;
  logic [SQ_W-1:0]           sq_q;
  logic [DIV_DW-1:0]         sumsq_q;
  logic [ROOT_W-1:0]         root_q;
  logic                      neg_q;
  logic signed [ELEM_W-1:0]  norm_q;
  logic                      out_valid_q, out_last_q;
  logic                      div_start_q, sqrt_start_q;
  logic [DIV_DW-1:0]         div_a_q;
  logic [DIV_VW-1:0]         div_b_q;
  logic [SQRT_W-1:0]         sqrt_in_q;

  logic                      div_done, sqrt_done;
  logic [DIV_DW-1:0]         div_quo;
  logic [ROOT_W-1:0]         sqrt_root;
  logic [ELEM_W-1:0]         rdata;
  logic                      ram_we, in_acc, full, is_end;
  logic [AW-1:0]             ram_addr;
  logic signed [ELEM_W:0]    dev;
  logic [ELEM_W-1:0]         dev_abs;
  logic signed [SUM_W-1:0]   sum_nx;
  logic [SUM_W-1:0]          sum_abs;
  logic [CW-1:0]             cnt_nx;
  logic [VAR_W:0]            var_eps;
  logic signed [ELEM_W-1:0]  sat_val;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CW'(MAX_LEN));
  assign ram_we     = in_acc && !full;
  assign ram_addr   = (state_q == S_LOAD) ? cnt_q[AW-1:0] : idx_q;
  assign cnt_nx     = full ? cnt_q : cnt_q + 1'b1;
  assign is_end     = (CW'(idx_q) == n_q - 1'b1);

  assign dev     = $signed({rdata[ELEM_W-1], rdata}) - $signed({mean_q[ELEM_W-1], mean_q});
  assign dev_abs = dev[ELEM_W] ? ELEM_W'(-dev) : dev[ELEM_W-1:0];
  assign sum_nx  = full ? sum_q : sum_q + SUM_W'(element_i);
  assign sum_abs = sum_nx[SUM_W-1] ? -sum_nx : sum_nx;
  assign var_eps = {1'b0, div_quo[VAR_W-1:0]} + {{(VAR_W+1-EPS_W){1'b0}}, eps_q};

  always_comb begin
    if (neg_q) begin
      sat_val = (div_quo > DIV_DW'(32768)) ? SAT_NEG : -$signed(div_quo[ELEM_W-1:0]);
    end else begin
      sat_val = (div_quo > DIV_DW'(32767)) ? SAT_POS : $signed(div_quo[ELEM_W-1:0]);
    end
  end

  lnorm_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (element_i),
    .rdata_o (rdata)
  );

  lnorm_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  lnorm_sqrt #(.W(SQRT_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .value_i (sqrt_in_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      cnt_q        <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      sum_q        <= '0;
      ovf_q        <= 1'b0;
      eps_q        <= EPS_W'(1);
      mean_q       <= '0;
      sq_q         <= '0;
      sumsq_q      <= '0;
      root_q       <= '0;
      neg_q        <= 1'b0;
      norm_q       <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_a_q      <= '0;
      div_b_q      <= '0;
      sqrt_in_q    <= '0;
    end else begin
      div_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      if (eps_we_i) begin
        eps_q <= eps_wdata_i;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
              sum_q <= sum_nx;
            end
            if (last_i) begin
              n_q         <= cnt_nx;
              div_a_q     <= DIV_DW'(sum_abs);
              div_b_q     <= DIV_VW'(cnt_nx);
              div_start_q <= 1'b1;
              state_q     <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_q  <= sum_q[SUM_W-1] ? -$signed(div_quo[ELEM_W-1:0])
                                      : $signed(div_quo[ELEM_W-1:0]);
            idx_q   <= '0;
            sumsq_q <= '0;
            state_q <= S_VRD;
          end
        end
        S_VRD: begin
          state_q <= S_VSQ;
        end
        S_VSQ: begin
          sq_q    <= dev_abs * dev_abs;
          state_q <= S_VACC;
        end
        S_VACC: begin
          sumsq_q <= sumsq_q + DIV_DW'(sq_q);
          if (is_end) begin
            div_a_q     <= sumsq_q + DIV_DW'(sq_q);
            div_b_q     <= DIV_VW'(n_q);
            div_start_q <= 1'b1;
            state_q     <= S_VDIV;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_VRD;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            sqrt_in_q    <= SQRT_W'({var_eps, 16'b0});
            sqrt_start_q <= 1'b1;
            state_q      <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            root_q  <= sqrt_root;
            idx_q   <= '0;
            state_q <= S_ORD;
          end
        end
        S_ORD: begin
          state_q <= S_OCALC;
        end
        S_OCALC: begin
          neg_q <= dev[ELEM_W];
          if (root_q == '0) begin
            if (dev[ELEM_W]) begin
              norm_q <= SAT_NEG;
            end else if (dev == '0) begin
              norm_q <= '0;
            end else begin
              norm_q <= SAT_POS;
            end
            out_valid_q <= 1'b1;
            out_last_q  <= is_end;
            state_q     <= S_OUT;
          end else begin
            div_a_q     <= DIV_DW'({dev_abs, {NORM_SHIFT{1'b0}}});
            div_b_q     <= root_q;
            div_start_q <= 1'b1;
            state_q     <= S_ODIV;
          end
        end
        S_ODIV: begin
          if (div_done) begin
            norm_q      <= sat_val;
            out_valid_q <= 1'b1;
            out_last_q  <= is_end;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (is_end) begin
              cnt_q   <= '0;
              sum_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_ORD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normalized_o = norm_q;
  assign last_res_o   = out_last_q;
  assign truncated_o  = ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_LEN))
    else $error("element count beyond capacity");

  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (n_q != '0) && (CW'(idx_q) < n_q))
    else $error("result beat outside the stored vector");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_res_o |=> (cnt_q == '0) && !ovf_q && !in_stall_o)
    else $error("state not cleared after final result beat");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o && !out_valid_o)
    else $error("input not stalled after closing beat");
endmodule
